// ----- sv/pes_pkg.sv -----
package pes_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Width of the operand word and of the divider step counter.
  localparam int WORD_W    = 32;
  localparam int NUM_W     = 31;
  localparam int DIV_STEPS = WORD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Token kinds.
  localparam logic KIND_NUMBER   = 1'b0;
  localparam logic KIND_OPERATOR = 1'b1;

  // Operator codes.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  // Error causes.
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_FEW      = 3'd1;
  localparam logic [2:0] CAUSE_DIVZERO  = 3'd2;
  localparam logic [2:0] CAUSE_LEFTOVER = 3'd3;
  localparam logic [2:0] CAUSE_OVERFLOW = 3'd4;

  typedef struct packed {
    logic             token_kind;
    logic [NUM_W-1:0] number_value;
    logic [2:0]       operator_code;
    logic             last_token;
  } token_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     error_flag;
    logic [2:0]               error_cause;
  } result_t;

  // Request to and response from the iterative divider.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/pes_stack_ram.sv -----
module pes_stack_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [pes_pkg::PTR_W-1:0]   wr_addr,
  input  logic [pes_pkg::WORD_W-1:0]  wr_data,
  input  logic [pes_pkg::PTR_W-1:0]   rd_addr,
  output logic [pes_pkg::WORD_W-1:0]  rd_data
);

  logic [pes_pkg::WORD_W-1:0] mem [pes_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/pes_divider.sv -----
module pes_divider (
  input  logic              clk,
  input  logic              rst,
  input  pes_pkg::div_req_t req,
  output pes_pkg::div_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} state_t;

  state_t                      state;
  logic [pes_pkg::WORD_W-1:0]  rem;
  logic [pes_pkg::WORD_W-1:0]  quot;
  logic [pes_pkg::WORD_W-1:0]  dvsr;
  logic                        neg;
  logic [pes_pkg::STEP_W-1:0]  step;

  logic [pes_pkg::WORD_W:0]    shifted;
  logic [pes_pkg::WORD_W:0]    diff;
  logic                        fits;

  // One restoring step per cycle on the magnitudes.
  assign shifted = {rem, quot[pes_pkg::WORD_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign fits    = !diff[pes_pkg::WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            neg   <= req.dividend[pes_pkg::WORD_W-1] ^ req.divisor[pes_pkg::WORD_W-1];
            quot  <= req.dividend[pes_pkg::WORD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
            dvsr  <= req.divisor[pes_pkg::WORD_W-1] ? (~req.divisor + 1'b1) : req.divisor;
            rem   <= '0;
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem  <= fits ? diff[pes_pkg::WORD_W-1:0] : shifted[pes_pkg::WORD_W-1:0];
          quot <= {quot[pes_pkg::WORD_W-2:0], fits};
          step <= step + 1'b1;
          if (step == pes_pkg::STEP_W'(pes_pkg::DIV_STEPS - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          rsp.quotient <= neg ? (~quot + 1'b1) : quot;
          rsp.done     <= 1'b1;
          state        <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/postfix_stack_evaluator.sv -----
// A number token is handled in S_IDLE alone; add, subtract, multiply and other operators
// pass through S_READ and S_OP, a divide through S_READ, S_OP and S_DIV (one stack memory
// read, then a 32-step restoring divider, one quotient bit per cycle). The last token of an
// expression then passes S_END to post the result beat. Tokens are taken one at a time.
// Reset (synchronous, active high) empties the stack, clears the error latch and drops
// result_valid. The stack memory itself is not cleared; only written entries are ever used.
module postfix_stack_evaluator (
  input  logic             clk,
  input  logic             rst,
  input  logic             token_valid,
  output logic             token_stall,
  input  pes_pkg::token_t  token,
  output logic             result_valid,
  input  logic             result_stall,
  output pes_pkg::result_t result
);

  // S_IDLE takes a token. Numbers, errors and ignored tokens finish there. An operator
  // reads its left operand from the memory (S_READ), combines it with the cached top of
  // stack (S_OP) or hands both to the divider (S_DIV), and writes the result back below.
  // S_END closes an expression and holds until the result register is free.
  typedef enum logic [2:0] {S_IDLE, S_READ, S_OP, S_DIV, S_END} state_t;

  state_t                      state;
  logic [pes_pkg::CNT_W-1:0]   count;
  logic [pes_pkg::WORD_W-1:0]  tos;
  logic                        err;
  logic [2:0]                  err_code;
  logic                        last;
  logic [2:0]                  code;

  logic                        ram_we;
  logic [pes_pkg::PTR_W-1:0]   ram_waddr;
  logic [pes_pkg::WORD_W-1:0]  ram_wdata;
  logic [pes_pkg::WORD_W-1:0]  ram_rdata;
  logic [pes_pkg::CNT_W-1:0]   below_cnt;
  logic [pes_pkg::PTR_W-1:0]   below_ptr;
  logic [pes_pkg::WORD_W-1:0]  alu_res;
  logic                        push_ok;
  logic                        stack_full;
  logic                        out_free;
  pes_pkg::div_req_t           div_req;
  pes_pkg::div_rsp_t           div_rsp;

  // The top of stack lives in a register, so an operator needs only one memory read:
  // the left operand, two places below the count. The memory still gets every write,
  // so the entry under the top is valid once the top is popped.
  assign below_cnt  = count - pes_pkg::CNT_W'(2);
  assign below_ptr  = below_cnt[pes_pkg::PTR_W-1:0];
  assign stack_full = (count >= pes_pkg::CNT_W'(pes_pkg::STACK_DEPTH));
  assign out_free   = !result_valid || !result_stall;

  assign token_stall = (state != S_IDLE);

  assign push_ok = token_valid && (state == S_IDLE) && !err
                   && (token.token_kind == pes_pkg::KIND_NUMBER) && !stack_full;

  always_comb begin
    unique case (code)
      pes_pkg::OP_ADD: alu_res = ram_rdata + tos;
      pes_pkg::OP_SUB: alu_res = ram_rdata - tos;
      pes_pkg::OP_MUL: alu_res = ram_rdata * tos;
      default:         alu_res = '0;
    endcase
  end

  // Memory writes come from a push in S_IDLE or a write-back in S_OP / S_DIV. The memory reads
  // below the top every cycle; S_OP uses it after any earlier write has landed, so no forwarding is needed.
  assign ram_we    = push_ok
                     || ((state == S_OP) && (code != pes_pkg::OP_DIV))
                     || ((state == S_DIV) && div_rsp.done);
  assign ram_waddr = push_ok ? count[pes_pkg::PTR_W-1:0] : below_ptr;
  assign ram_wdata = push_ok ? {1'b0, token.number_value}
                   : ((state == S_OP) ? alu_res : div_rsp.quotient);

  assign div_req.start    = (state == S_OP) && (code == pes_pkg::OP_DIV);
  assign div_req.dividend = ram_rdata;
  assign div_req.divisor  = tos;

  pes_stack_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (below_ptr),
    .rd_data (ram_rdata)
  );

  pes_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= 1'b0;
      err_code     <= pes_pkg::CAUSE_NONE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (token_valid) begin
            last  <= token.last_token;
            code  <= token.operator_code;
            state <= token.last_token ? S_END : S_IDLE;
            if (err) begin
              // After an error the rest of the expression is dropped.
            end else if (token.token_kind == pes_pkg::KIND_NUMBER) begin
              if (stack_full) begin
                err      <= 1'b1;
                err_code <= pes_pkg::CAUSE_OVERFLOW;
              end else begin
                tos   <= {1'b0, token.number_value};
                count <= count + 1'b1;
              end
            end else if (count < pes_pkg::CNT_W'(2)) begin
              err      <= 1'b1;
              err_code <= pes_pkg::CAUSE_FEW;
            end else if ((token.operator_code == pes_pkg::OP_DIV) && (tos == '0)) begin
              err      <= 1'b1;
              err_code <= pes_pkg::CAUSE_DIVZERO;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_OP;
        end
        S_OP: begin
          if (code == pes_pkg::OP_DIV) begin
            state <= S_DIV;
          end else begin
            tos   <= alu_res;
            count <= count - 1'b1;
            state <= last ? S_END : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            tos   <= div_rsp.quotient;
            count <= count - 1'b1;
            state <= last ? S_END : S_IDLE;
          end
        end
        S_END: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (err) begin
              result.result_value <= '0;
              result.error_flag   <= 1'b1;
              result.error_cause  <= err_code;
            end else if (count != pes_pkg::CNT_W'(1)) begin
              result.result_value <= '0;
              result.error_flag   <= 1'b1;
              result.error_cause  <= pes_pkg::CAUSE_LEFTOVER;
            end else begin
              result.result_value <= tos;
              result.error_flag   <= 1'b0;
              result.error_cause  <= pes_pkg::CAUSE_NONE;
            end
            count    <= '0;
            err      <= 1'b0;
            err_code <= pes_pkg::CAUSE_NONE;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pes_checker.sv -----
module pes_checker (
  input logic             clk,
  input logic             rst,
  input logic             token_valid,
  input logic             token_stall,
  input logic             result_valid,
  input logic             result_stall,
  input pes_pkg::result_t result
);

  // A stalled result beat stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // After reset the block is empty and ready for a token.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !token_stall)
    else $error("block not idle after reset");

  // A good result carries no cause; a failed one carries a value of zero.
  a_ok_no_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.error_flag |-> result.error_cause == pes_pkg::CAUSE_NONE)
    else $error("cause reported without error flag");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_flag |->
      result.result_value == '0
      && (result.error_cause == pes_pkg::CAUSE_FEW
          || result.error_cause == pes_pkg::CAUSE_DIVZERO
          || result.error_cause == pes_pkg::CAUSE_LEFTOVER
          || result.error_cause == pes_pkg::CAUSE_OVERFLOW))
    else $error("malformed error beat");

endmodule

bind postfix_stack_evaluator pes_checker u_pes_checker (.*);
